// ----- design/rfalu_pkg.sv -----
// Package: request/result types and operation codes for the register-file ALU.
`timescale 1ns / 1ps
`default_nettype none
package rfalu_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned KIND_W = 5;

    localparam logic [KIND_W-1:0] OP_MOV  = 5'd0;
    localparam logic [KIND_W-1:0] OP_ADD  = 5'd1;
    localparam logic [KIND_W-1:0] OP_SUB  = 5'd2;
    localparam logic [KIND_W-1:0] OP_MUL  = 5'd3;
    localparam logic [KIND_W-1:0] OP_SDIV = 5'd4;
    localparam logic [KIND_W-1:0] OP_UDIV = 5'd5;
    localparam logic [KIND_W-1:0] OP_SREM = 5'd6;
    localparam logic [KIND_W-1:0] OP_UREM = 5'd7;
    localparam logic [KIND_W-1:0] OP_AND  = 5'd8;
    localparam logic [KIND_W-1:0] OP_OR   = 5'd9;
    localparam logic [KIND_W-1:0] OP_XOR  = 5'd10;
    localparam logic [KIND_W-1:0] OP_SHL  = 5'd11;
    localparam logic [KIND_W-1:0] OP_LSHR = 5'd12;
    localparam logic [KIND_W-1:0] OP_ASHR = 5'd13;
    localparam logic [KIND_W-1:0] OP_NOT  = 5'd14;
    localparam logic [KIND_W-1:0] OP_EQ   = 5'd15;
    localparam logic [KIND_W-1:0] OP_NE   = 5'd16;
    localparam logic [KIND_W-1:0] OP_SLT  = 5'd17;
    localparam logic [KIND_W-1:0] OP_SLE  = 5'd18;
    localparam logic [KIND_W-1:0] OP_SGT  = 5'd19;
    localparam logic [KIND_W-1:0] OP_SGE  = 5'd20;
    localparam logic [KIND_W-1:0] OP_ULT  = 5'd21;
    localparam logic [KIND_W-1:0] OP_ULE  = 5'd22;
    localparam logic [KIND_W-1:0] OP_UGT  = 5'd23;
    localparam logic [KIND_W-1:0] OP_UGE  = 5'd24;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  dest_reg;
        logic              use_immediate;
        logic [IDX_W-1:0]  src_reg;
        logic [DATA_W-1:0] immediate;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]  written_reg;
        logic [DATA_W-1:0] written_value;
        logic              divide_by_zero;
    } rsp_t;

    // Divider control between the sequencer and the divide unit.
    typedef struct packed {
        logic start;
        logic sgn;
    } div_ctl_t;

endpackage
`default_nettype wire

// ----- design/rfalu_div.sv -----
// Iterative 64-bit divider, one quotient bit per cycle, signed or unsigned.
`timescale 1ns / 1ps
`default_nettype none
module rfalu_div
    import rfalu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire div_ctl_t          ctl,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic [DATA_W-1:0]      quotient,
    output logic [DATA_W-1:0]      remainder
);

    logic              busy_reg, busy_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic              qneg_reg, qneg_next;
    logic              rneg_reg, rneg_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] a_abs;
    logic [DATA_W-1:0] b_abs;

    always_comb
    begin
        a_abs = (ctl.sgn && dividend[DATA_W-1]) ? (~dividend + 1'b1) : dividend;
        b_abs = (ctl.sgn && divisor[DATA_W-1]) ? (~divisor + 1'b1) : divisor;
        trial = {r_reg, q_reg[DATA_W-1]} - {1'b0, d_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            q_next    = a_abs;
            r_next    = '0;
            d_next    = b_abs;
            qneg_next = ctl.sgn && (dividend[DATA_W-1] ^ divisor[DATA_W-1]);
            rneg_next = ctl.sgn && dividend[DATA_W-1];
        end
        else if (busy_reg)
        begin
            // Restoring step: shift in the next dividend bit and try the subtract.
            if (!trial[DATA_W])
            begin
                r_next = trial[DATA_W-1:0];
                q_next = {q_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DATA_W-2:0], q_reg[DATA_W-1]};
                q_next = {q_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? (~q_reg + 1'b1) : q_reg;
    assign remainder = rneg_reg ? (~r_reg + 1'b1) : r_reg;

endmodule
`default_nettype wire

// ----- design/rfalu_alu.sv -----
// Combinational ALU for every operation except divide and multiply.
`timescale 1ns / 1ps
`default_nettype none
module rfalu_alu
    import rfalu_pkg::*;
(
    input  wire logic [KIND_W-1:0] kind,
    input  wire logic [DATA_W-1:0] a,
    input  wire logic [DATA_W-1:0] b,
    output logic [DATA_W-1:0]      result
);

    logic [5:0] sh;
    logic       slt;
    logic       sgt;
    logic       ult;
    logic       ugt;
    logic       eq;

    always_comb
    begin
        sh  = b[5:0];
        eq  = (a == b);
        ult = (a < b);
        ugt = (a > b);
        slt = ($signed(a) < $signed(b));
        sgt = ($signed(a) > $signed(b));
        case (kind)
            OP_MOV:  result = b;
            OP_ADD:  result = a + b;
            OP_SUB:  result = a - b;
            OP_AND:  result = a & b;
            OP_OR:   result = a | b;
            OP_XOR:  result = a ^ b;
            OP_SHL:  result = a << sh;
            OP_LSHR: result = a >> sh;
            OP_ASHR: result = DATA_W'($signed(a) >>> sh);
            OP_NOT:  result = ~a;
            OP_EQ:   result = DATA_W'(eq);
            OP_NE:   result = DATA_W'(!eq);
            OP_SLT:  result = DATA_W'(slt);
            OP_SLE:  result = DATA_W'(!sgt);
            OP_SGT:  result = DATA_W'(sgt);
            OP_SGE:  result = DATA_W'(!slt);
            OP_ULT:  result = DATA_W'(ult);
            OP_ULE:  result = DATA_W'(!ugt);
            OP_UGT:  result = DATA_W'(ugt);
            OP_UGE:  result = DATA_W'(!ult);
            default: result = a;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/register_file_integer_alu.sv -----
// Top level: register file memory, operand sequencer and result register.
//
// One request on req (valid/ready) carries an operation, a destination
// register, and either a second register or a 64-bit immediate. One result
// comes back on rsp (valid/ready) with the register index, the value written
// and the divide-by-zero flag.
// Requests are handled one at a time. Simple operations, and divides by zero,
// go from acceptance to result through destination read, second read, and
// execute and write back; multiply adds states MUL1, MUL2 and WAIT for its three
// registered 32x32 partial products and their sum; divide and remainder wait
// in state DIV for the one-bit-per-cycle divider.
// A new request is accepted the cycle after a result is registered, so one
// request is finished before the next is taken.
// After reset a clearing pass writes zero to every register, one per cycle;
// req_ready stays low meanwhile.
// A stalled result sits in the output register; a following request is still
// accepted and read, but its write-back and result wait until that register
// is free.
`timescale 1ns / 1ps
`default_nettype none
module register_file_integer_alu
    import rfalu_pkg::*;
#(
    parameter int unsigned REG_COUNT = 256
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int unsigned IDX_RECIP = ((1 << 18) + REG_COUNT - 1) / REG_COUNT;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RDA   = 4'd2;
    localparam logic [3:0] ST_RDB   = 4'd3;
    localparam logic [3:0] ST_EXEC  = 4'd4;
    localparam logic [3:0] ST_MUL1  = 4'd5;
    localparam logic [3:0] ST_MUL2  = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_WAIT  = 4'd8;

    logic [DATA_W-1:0] mem [REG_COUNT];
    logic [DATA_W-1:0] rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;

    logic [3:0]        state_reg, state_next;
    logic [AW:0]       clr_reg, clr_next;
    req_t              cur_reg;
    logic [AW-1:0]     dst_reg_q;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg;
    logic [DATA_W-1:0] prod;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              out_free;
    logic              accept;
    logic [DATA_W-1:0] alu_res;
    logic              is_div;
    logic              div_signed;
    logic              div_rem;
    logic              b_zero;
    div_ctl_t          dctl;
    logic              div_done;
    logic [DATA_W-1:0] div_q, div_r;

    function automatic logic [AW-1:0] reduce_idx(input logic [IDX_W-1:0] raw);
        logic [25:0]      prod_q;
        logic [IDX_W-1:0] quo;
        logic [IDX_W:0]   rem;
        begin
            // Index modulo REG_COUNT by reciprocal multiplication, exact for any
            // 8-bit index.
            prod_q = 26'(raw) * 26'(IDX_RECIP);
            quo    = prod_q[25:18];
            rem    = {1'b0, raw} - (IDX_W+1)'(quo) * (IDX_W+1)'(REG_COUNT);
            reduce_idx = AW'(rem);
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    rfalu_alu u_alu (
        .kind   (cur_reg.kind),
        .a      (a_reg),
        .b      (b_reg),
        .result (alu_res)
    );

    rfalu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (dctl),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign dst_reg_q = reduce_idx(cur_reg.dest_reg);
    assign is_div    = (cur_reg.kind == OP_SDIV) || (cur_reg.kind == OP_UDIV) ||
                       (cur_reg.kind == OP_SREM) || (cur_reg.kind == OP_UREM);
    assign div_signed = (cur_reg.kind == OP_SDIV) || (cur_reg.kind == OP_SREM);
    assign div_rem    = (cur_reg.kind == OP_SREM) || (cur_reg.kind == OP_UREM);
    assign b_zero     = (b_reg == '0);
    assign prod = pp_ll_reg + {pp_lh_reg[31:0], 32'd0} + {pp_hl_reg[31:0], 32'd0};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = dst_reg_q;
        mem_wdata      = '0;
        mem_raddr      = dst_reg_q;
        dctl.start     = 1'b0;
        dctl.sgn       = div_signed;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[AW-1:0];
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(REG_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mem_raddr  = reduce_idx(req.dest_reg);
                    state_next = ST_RDA;
                end
            end
            ST_RDA:
            begin
                // The destination register's value arrives in this cycle.
                a_next     = rdata_reg;
                mem_raddr  = reduce_idx(cur_reg.src_reg);
                state_next = ST_RDB;
            end
            ST_RDB:
            begin
                b_next = cur_reg.use_immediate ? cur_reg.immediate : rdata_reg;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (cur_reg.kind == OP_MUL)
                begin
                    state_next = ST_MUL1;
                end
                else if (is_div && !b_zero)
                begin
                    dctl.start = 1'b1;
                    state_next = ST_DIV;
                end
                else if (out_free)
                begin
                    rsp_next.written_reg    = IDX_W'(dst_reg_q);
                    rsp_next.written_value  = is_div ? '0 : alu_res;
                    rsp_next.divide_by_zero = is_div;
                    rsp_valid_next = 1'b1;
                    mem_we     = 1'b1;
                    mem_wdata  = rsp_next.written_value;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                a_next     = prod;
                state_next = ST_WAIT;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    a_next     = div_rem ? div_r : div_q;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    rsp_next.written_reg    = IDX_W'(dst_reg_q);
                    rsp_next.written_value  = a_reg;
                    rsp_next.divide_by_zero = 1'b0;
                    rsp_valid_next = 1'b1;
                    mem_we     = 1'b1;
                    mem_wdata  = a_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg <= req;
        end
        a_reg     <= a_next;
        b_reg     <= b_next;
        rsp_reg   <= rsp_next;
        pp_ll_reg <= 64'(a_reg[31:0]) * 64'(b_reg[31:0]);
        pp_lh_reg <= 64'(a_reg[31:0]) * 64'(b_reg[63:32]);
        pp_hl_reg <= 64'(a_reg[63:32]) * 64'(b_reg[31:0]);
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

// ----- tb/tb_register_file_integer_alu.sv -----
// Testbench for the register-file integer ALU: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_register_file_integer_alu;
    import rfalu_pkg::*;

    localparam logic [63:0] MIN_S = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_1 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [4:0]  OP_UNUSED_FIRST = 5'd25;
    localparam logic [4:0]  OP_UNUSED_LAST  = 5'd31;

    // Holds the predicted register file and the queue of results still awaited.
    class alu_scoreboard;
        logic [63:0] regs [256];
        rsp_t        pending [$];
        int          errors;
        int          checked;

        function new();
            foreach (regs[i]) regs[i] = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void note_request(req_t r);
            logic [63:0] a, b, q, res;
            logic [5:0]  sh;
            logic        dz, wr;
            rsp_t        e;
            a   = regs[r.dest_reg];
            b   = r.use_immediate ? r.immediate : regs[r.src_reg];
            sh  = b[5:0];
            res = a;
            dz  = 1'b0;
            wr  = 1'b1;
            case (r.kind) inside
                OP_MOV:  res = b;
                OP_ADD:  res = a + b;
                OP_SUB:  res = a - b;
                OP_MUL:  res = a * b;
                OP_SDIV, OP_SREM, OP_UDIV, OP_UREM:
                begin
                    if (b == '0)
                    begin
                        res = '0;
                        dz = 1'b1;
                    end
                    else if (r.kind == OP_UDIV)
                        res = a / b;
                    else if (r.kind == OP_UREM)
                        res = a % b;
                    else if (r.kind == OP_SDIV)
                    begin
                        q = (a[63] ? -a : a) / (b[63] ? -b : b);
                        res = (a[63] ^ b[63]) ? -q : q;
                    end
                    else
                    begin
                        q = (a[63] ? -a : a) % (b[63] ? -b : b);
                        res = a[63] ? -q : q;
                    end
                end
                OP_AND:  res = a & b;
                OP_OR:   res = a | b;
                OP_XOR:  res = a ^ b;
                OP_SHL:  res = a << sh;
                OP_LSHR: res = a >> sh;
                OP_ASHR: res = $unsigned($signed(a) >>> sh);
                OP_NOT:  res = ~a;
                OP_EQ:   res = 64'(a == b);
                OP_NE:   res = 64'(a != b);
                OP_SLT:  res = 64'($signed(a) < $signed(b));
                OP_SLE:  res = 64'($signed(a) <= $signed(b));
                OP_SGT:  res = 64'($signed(a) > $signed(b));
                OP_SGE:  res = 64'($signed(a) >= $signed(b));
                OP_ULT:  res = 64'(a < b);
                OP_ULE:  res = 64'(a <= b);
                OP_UGT:  res = 64'(a > b);
                OP_UGE:  res = 64'(a >= b);
                default: wr = 1'b0;
            endcase
            if (wr)
                regs[r.dest_reg] = res;
            e.written_reg = r.dest_reg;
            e.written_value = res;
            e.divide_by_zero = dz;
            pending.insert(pending.size(), e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.written_reg !== e.written_reg)
            begin
                $display("%0t: written_reg expected %0d actual %0d", $time,
                         e.written_reg, got.written_reg);
                errors++;
            end
            if (got.written_value !== e.written_value)
            begin
                $display("%0t: written_value expected %h actual %h", $time,
                         e.written_value, got.written_value);
                errors++;
            end
            if (got.divide_by_zero !== e.divide_by_zero)
            begin
                $display("%0t: divide_by_zero expected %b actual %b", $time,
                         e.divide_by_zero, got.divide_by_zero);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    alu_scoreboard sb = new();
    int unsigned   cycle_count = 0;
    int unsigned   sent = 0;

    register_file_integer_alu dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The result side holds rsp_ready low for a random stall, sometimes none, before each result.
    initial
    begin : result_side
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            sb.check_result(rsp);
        end
    end

    task automatic send_request(req_t r, bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(r);
        sent++;
    endtask

    task automatic send_op(logic [4:0] k, logic [7:0] d, logic imm, logic [7:0] s,
                           logic [63:0] v);
        req_t r;
        r.kind = k;
        r.dest_reg = d;
        r.use_immediate = imm;
        r.src_reg = s;
        r.immediate = v;
        send_request(r, 1'b0);
    endtask

    function automatic logic [63:0] random_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ALL_1;
            2: return MIN_S;
            3: return 64'($urandom_range(0, 70));
            4: return -64'($urandom_range(1, 70));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : request_side
        req_t r;
        int   i;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: boundary values, zero divisors, the signed overflow case and shifts.
        send_op(OP_MOV, 8'd0, 1'b1, 8'd0, MIN_S);
        send_op(OP_MOV, 8'd255, 1'b1, 8'd0, ALL_1);
        send_op(OP_SDIV, 8'd0, 1'b0, 8'd255, 64'd0);
        send_op(OP_MOV, 8'd1, 1'b1, 8'd0, MIN_S);
        send_op(OP_SREM, 8'd1, 1'b0, 8'd255, 64'd0);
        send_op(OP_UDIV, 8'd255, 1'b1, 8'd0, 64'd0);
        send_op(OP_SREM, 8'd2, 1'b0, 8'd3, 64'd0);
        send_op(OP_MOV, 8'd2, 1'b1, 8'd0, -64'd7);
        send_op(OP_SREM, 8'd2, 1'b1, 8'd0, 64'd2);
        send_op(OP_MOV, 8'd3, 1'b1, 8'd0, -64'd7);
        send_op(OP_SDIV, 8'd3, 1'b1, 8'd0, 64'd2);
        send_op(OP_UREM, 8'd3, 1'b1, 8'd0, 64'd0);
        send_op(OP_MOV, 8'd4, 1'b1, 8'd0, MIN_S);
        send_op(OP_ASHR, 8'd4, 1'b1, 8'd0, 64'hFFC0 | 64'd63);
        send_op(OP_LSHR, 8'd0, 1'b1, 8'd0, 64'd65);
        send_op(OP_SHL, 8'd255, 1'b1, 8'd0, 64'd63);
        send_op(OP_NOT, 8'd5, 1'b1, 8'd0, ALL_1);
        send_op(OP_MUL, 8'd5, 1'b0, 8'd5, 64'd0);
        send_op(OP_SLT, 8'd6, 1'b1, 8'd0, MIN_S);
        send_op(OP_UGE, 8'd7, 1'b1, 8'd0, ALL_1);
        send_op(OP_UNUSED_LAST, 8'd255, 1'b0, 8'd0, 64'd0);
        send_op(OP_UNUSED_FIRST, 8'd4, 1'b1, 8'd0, ALL_1);

        // The sender holds off here until every expected result has come back.
        drain();

        for (i = 0; i < 450; i++)
        begin
            r.kind = ($urandom_range(0, 19) == 0)
                     ? 5'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST))
                     : 5'($urandom_range(0, 24));
            // A small pool of registers keeps values chaining between requests.
            r.dest_reg = ($urandom_range(0, 3) == 0) ? 8'($urandom())
                                                     : 8'($urandom_range(0, 7));
            r.use_immediate = 1'($urandom());
            r.src_reg = ($urandom_range(0, 3) == 0) ? 8'($urandom())
                                                    : 8'($urandom_range(0, 7));
            r.immediate = random_word();
            send_request(r, i % 50 < 10);
            if (i == 225)
                drain();
        end
        drain();
        repeat (100) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $display("%0d results never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("Sent %0d requests covering all operations, zero divisors and unused codes;",
                 sent);
        $display("%0d results compared against the predicted register file.", sb.checked);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
